>>> rtl/mpc_pkg.sv
// mpc_pkg: shared widths, codes and types of the midpoint circle point generator
// used by every file in rtl, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package mpc_pkg;

	localparam int COORD_W  = 12;
	localparam int RADIUS_W = 11;
	localparam int DEC_W    = 16;
	localparam int NUM_OCT  = 8;
	localparam int OCT_W    = 3;

	localparam logic [RADIUS_W-1:0] MAX_RADIUS = RADIUS_W'(2047);

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef point_t [NUM_OCT-1:0] point_set_t;

	// one request after the state update
	typedef struct packed {
		logic   is_done;
		logic   start;
		point_t pt;
	} item_t;

	// mirrored images with the mask of the ones still to be sent
	typedef struct packed {
		logic               is_done;
		logic [NUM_OCT-1:0] sel;
		point_set_t         img;
	} batch_t;

endpackage

`default_nettype wire

>>> rtl/mpc_req_if.sv
// mpc_req_if: valid/ready request channel of the circle point generator
// depends on mpc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface mpc_req_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [mpc_pkg::RADIUS_W-1:0] radius;

	modport source (output valid, func, radius, input ready);
	modport sink   (input valid, func, radius, output ready);
endinterface

`default_nettype wire

>>> rtl/mpc_res_if.sv
// mpc_res_if: valid/ready result channel of the circle point generator
// depends on mpc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface mpc_res_if;
	logic                      valid;
	logic                      ready;
	mpc_pkg::coord_t           point_x;
	mpc_pkg::coord_t           point_y;
	logic [mpc_pkg::OCT_W-1:0] octant;
	logic                      point_valid;
	logic                      last;
	logic                      done_res;

	modport source (output valid, point_x, point_y, octant, point_valid, last, done_res,
		input ready);
	modport sink   (input valid, point_x, point_y, octant, point_valid, last, done_res,
		output ready);
endinterface

`default_nettype wire

>>> rtl/mpc_step.sv
// mpc_step: circle state (x, y, decision) and the input register stage
// depends on mpc_pkg and mpc_req_if
`timescale 1ns / 1ps
`default_nettype none

module mpc_step (
	input  wire logic           clk,
	input  wire logic           arst_n,
	mpc_req_if.sink             req,
	input  wire logic           free,
	output logic                item_valid,
	output mpc_pkg::item_t      item
);

	localparam int DW = mpc_pkg::DEC_W;
	localparam int CW = mpc_pkg::COORD_W;
	localparam int RW = mpc_pkg::RADIUS_W;

	localparam logic signed [DW-1:0] D_INIT = DW'(3);
	localparam logic signed [DW-1:0] D_DIAG = DW'(10);
	localparam logic signed [DW-1:0] D_AXIS = DW'(6);

	mpc_pkg::coord_t         x_q, y_q;
	logic signed [DW-1:0]    d_q;
	logic                    fin_q;
	logic                    s1_valid_q;
	mpc_pkg::item_t          item_s1;

	logic                    accept;
	logic [RW-1:0]           r_sat;
	mpc_pkg::coord_t         r_c;
	logic signed [DW-1:0]    r_e;
	logic signed [DW-1:0]    d_start;
	logic                    go;
	logic                    d_pos;
	mpc_pkg::coord_t         nx, ny;
	logic signed [DW-1:0]    nx_e, ny_e, nd;

	assign req.ready = !s1_valid_q || free;
	assign accept    = req.valid && req.ready;

	always_comb begin
		r_sat   = (req.radius > mpc_pkg::MAX_RADIUS) ? mpc_pkg::MAX_RADIUS : req.radius;
		r_c     = mpc_pkg::coord_t'({{(CW-RW){1'b0}}, r_sat});
		r_e     = DW'(r_c);
		d_start = D_INIT - (r_e <<< 1);
		go      = !fin_q && (y_q >= x_q);
		d_pos   = d_q > DW'(0);
		nx      = x_q + CW'(1);
		ny      = d_pos ? y_q - CW'(1) : y_q;
		nx_e    = DW'(nx);
		ny_e    = DW'(ny);
		nd      = d_pos ? d_q + ((nx_e - ny_e) <<< 2) + D_DIAG : d_q + (nx_e <<< 2) + D_AXIS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q        <= '0;
			y_q        <= '0;
			d_q        <= '0;
			fin_q      <= 1'b1;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (req.func == mpc_pkg::FUNC_START) begin
					x_q   <= '0;
					y_q   <= r_c;
					d_q   <= d_start;
					fin_q <= 1'b0;
				end else if (go) begin
					x_q <= nx;
					y_q <= ny;
					d_q <= nd;
				end else begin
					fin_q <= 1'b1;
				end
			end else if (free) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.func == mpc_pkg::FUNC_START) begin
				item_s1.is_done <= 1'b0;
				item_s1.start   <= 1'b1;
				item_s1.pt.x    <= '0;
				item_s1.pt.y    <= r_c;
			end else if (go) begin
				item_s1.is_done <= 1'b0;
				item_s1.start   <= 1'b0;
				item_s1.pt.x    <= nx;
				item_s1.pt.y    <= ny;
			end else begin
				item_s1.is_done <= 1'b1;
				item_s1.start   <= 1'b0;
				item_s1.pt      <= '0;
			end
		end
	end

	assign item_valid = s1_valid_q;
	assign item       = item_s1;

endmodule

`default_nettype wire

>>> rtl/mpc_dedup.sv
// mpc_dedup: eight-way mirroring and repeat suppression against two earlier requests
// depends on mpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mpc_dedup (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire mpc_pkg::item_t item,
	input  wire logic           free,
	output mpc_pkg::batch_t     batch,
	output logic                load
);

	localparam int NO = mpc_pkg::NUM_OCT;

	mpc_pkg::point_set_t   hist_pt_q [2];
	logic [NO-1:0]         hist_v_q  [2];

	mpc_pkg::point_set_t   img;
	logic [NO-1:0]         sel;
	logic                  adv;

	// octant order (x,y) (y,x) (y,-x) (x,-y) (-x,-y) (-y,-x) (-y,x) (-x,y)
	always_comb begin
		img[0].x = item.pt.x;   img[0].y = item.pt.y;
		img[1].x = item.pt.y;   img[1].y = item.pt.x;
		img[2].x = item.pt.y;   img[2].y = -item.pt.x;
		img[3].x = item.pt.x;   img[3].y = -item.pt.y;
		img[4].x = -item.pt.x;  img[4].y = -item.pt.y;
		img[5].x = -item.pt.y;  img[5].y = -item.pt.x;
		img[6].x = -item.pt.y;  img[6].y = item.pt.x;
		img[7].x = -item.pt.x;  img[7].y = item.pt.y;
	end

	always_comb begin
		logic seen;
		sel = '0;
		for (int o = 0; o < NO; o++) begin
			seen = 1'b0;
			for (int s = 0; s < 2; s++) begin
				for (int e = 0; e < NO; e++) begin
					if (!item.start && hist_v_q[s][e] && (hist_pt_q[s][e] == img[o])) begin
						seen = 1'b1;
					end
				end
			end
			for (int j = 0; j < o; j++) begin
				if (sel[j] && (img[j] == img[o])) begin
					seen = 1'b1;
				end
			end
			sel[o] = !seen;
		end
	end

	assign adv           = item_valid && free;
	assign load          = adv && (item.is_done || (|sel));
	assign batch.is_done = item.is_done;
	assign batch.sel     = item.is_done ? '0 : sel;
	assign batch.img     = img;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_v_q[0] <= '0;
			hist_v_q[1] <= '0;
		end else if (adv && !item.is_done) begin
			hist_v_q[1] <= item.start ? '0 : hist_v_q[0];
			hist_v_q[0] <= sel;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !item.is_done) begin
			hist_pt_q[1] <= hist_pt_q[0];
			hist_pt_q[0] <= img;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mpc_emit.sv
// mpc_emit: result buffer that sends the kept images one per cycle while the receiver is ready
// depends on mpc_pkg and mpc_res_if
`timescale 1ns / 1ps
`default_nettype none

module mpc_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mpc_pkg::batch_t batch,
	input  wire logic            load,
	output logic                 free,
	mpc_res_if.source            res
);

	localparam int NO = mpc_pkg::NUM_OCT;
	localparam int OW = mpc_pkg::OCT_W;

	mpc_pkg::point_set_t   img_q;
	logic [NO-1:0]         mask_q;
	logic                  done_q;

	logic [NO-1:0]         pick, rest;
	logic [OW-1:0]         idx;
	logic                  take;

	always_comb begin
		pick = mask_q & (~mask_q + NO'(1));
		rest = mask_q & ~pick;
		idx  = '0;
		for (int o = 0; o < NO; o++) begin
			if (pick[o]) begin
				idx = OW'(o);
			end
		end
	end

	assign res.valid       = done_q || (|mask_q);
	assign res.point_x     = done_q ? '0 : img_q[idx].x;
	assign res.point_y     = done_q ? '0 : img_q[idx].y;
	assign res.octant      = done_q ? '0 : idx;
	assign res.point_valid = !done_q;
	assign res.last        = done_q || (rest == '0);
	assign res.done_res    = done_q;

	assign take = res.valid && res.ready;
	assign free = !res.valid || (take && res.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			done_q <= 1'b0;
		end else if (load) begin
			mask_q <= batch.sel;
			done_q <= batch.is_done;
		end else if (take) begin
			mask_q <= rest;
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			img_q <= batch.img;
		end
	end

endmodule

`default_nettype wire

>>> rtl/midpoint_circle_point_generator.sv
// Midpoint circle point generator. A start request (func 0) loads a radius and sends the
// distinct mirror images of (0, radius); each step request (func 1) advances the midpoint
// loop once and sends the images of the new point in octant order, leaving out any point
// already sent by this request or the two before it. A step after the loop has ended sends
// one done result. Timing: a request is taken into the input register, mirrored and
// filtered in the next cycle, and loaded into the result buffer once that is free.
// The result buffer sends one result per cycle while the receiver is ready; a request
// has up to eight results (one for a done result, none when every image is a repeat),
// and the next request is accepted while the buffer still drains.
// depends on mpc_pkg, mpc_req_if, mpc_res_if, mpc_step, mpc_dedup, mpc_emit
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_point_generator (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mpc_req_if.sink     req,
	mpc_res_if.source   res
);

	logic               free;
	logic               item_valid;
	mpc_pkg::item_t     item;
	mpc_pkg::batch_t    batch;
	logic               load;

	mpc_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.free       (free),
		.item_valid (item_valid),
		.item       (item)
	);

	mpc_dedup u_dedup (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.free       (free),
		.batch      (batch),
		.load       (load)
	);

	mpc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.batch      (batch),
		.load       (load),
		.free       (free),
		.res        (res)
	);

	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res |-> res.last && !res.point_valid)
		else $error("done result not a lone final result");

	a_point_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.done_res |-> res.point_valid)
		else $error("point result without point flag");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !free |-> !req.ready)
		else $error("request taken while the input register is held");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free && item_valid)
		else $error("result buffer loaded while busy");

endmodule

`default_nettype wire

>>> sim/midpoint_circle_point_generator_tb.sv
// midpoint_circle_point_generator_tb: self-checking bench for the midpoint circle point generator
// clocked driver and monitor around a behavioural predictor of the point stream
// depends on mpc_pkg, mpc_req_if, mpc_res_if and midpoint_circle_point_generator
`timescale 1ns / 1ps

module midpoint_circle_point_generator_tb;

	localparam int REQ_GOAL       = 350;
	localparam int GAP_MAX        = 12;
	localparam int HOLD_CYCLES    = 250;
	localparam int HOLD_AT_FIRST  = 150;
	localparam int HOLD_AT_SECOND = 1000;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 32;
	localparam int HIST_DEPTH     = 3;
	localparam int RW             = mpc_pkg::RADIUS_W;
	localparam int OW             = mpc_pkg::OCT_W;
	localparam int NO             = mpc_pkg::NUM_OCT;

	typedef struct packed {
		logic          func;
		logic [RW-1:0] radius;
	} circle_req_t;

	typedef struct packed {
		mpc_pkg::coord_t px;
		mpc_pkg::coord_t py;
		logic [OW-1:0]   oct;
		logic            pv;
		logic            last;
		logic            done;
	} circle_pt_t;

	logic clk;
	logic arst_n;

	mpc_req_if req_ch ();
	mpc_res_if res_ch ();

	midpoint_circle_point_generator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	circle_req_t circle_reqs[$];
	circle_pt_t  due_points[$];

	int   fail_cnt    = 0;
	int   res_seen    = 0;
	int   idle_cycles = 0;
	logic req_hs      = 1'b0;
	logic res_hs      = 1'b0;

	// predictor state
	int   pos_x       = 0;
	int   pos_y       = 0;
	int   dec_var     = 0;
	logic circle_idle = 1'b1;
	int   hist_x[HIST_DEPTH][NO] = '{default: 0};
	int   hist_y[HIST_DEPTH][NO] = '{default: 0};
	logic hist_v[HIST_DEPTH][NO] = '{default: 1'b0};
	int   hist_head   = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic already_sent(input int px, input int py);
		for (int s = 0; s < HIST_DEPTH; s++)
			for (int o = 0; o < NO; o++)
				if (hist_v[s][o] && hist_x[s][o] == px && hist_y[s][o] == py)
					return 1'b1;
		return 1'b0;
	endfunction

	task automatic emit_mirrors();
		int         mx[NO];
		int         my[NO];
		circle_pt_t pts[NO];
		int         n;
		int         slot;
		n    = 0;
		slot = hist_head;
		mx[0] = pos_x;  my[0] = pos_y;
		mx[1] = pos_y;  my[1] = pos_x;
		mx[2] = pos_y;  my[2] = -pos_x;
		mx[3] = pos_x;  my[3] = -pos_y;
		mx[4] = -pos_x; my[4] = -pos_y;
		mx[5] = -pos_y; my[5] = -pos_x;
		mx[6] = -pos_y; my[6] = pos_x;
		mx[7] = -pos_x; my[7] = pos_y;
		for (int o = 0; o < NO; o++)
			hist_v[slot][o] = 1'b0;
		for (int o = 0; o < NO; o++) begin
			if (!already_sent(mx[o], my[o])) begin
				hist_x[slot][o] = mx[o];
				hist_y[slot][o] = my[o];
				hist_v[slot][o] = 1'b1;
				pts[n] = '{mpc_pkg::coord_t'(mx[o]), mpc_pkg::coord_t'(my[o]), OW'(o),
					1'b1, 1'b0, 1'b0};
				n++;
			end
		end
		if (n > 0)
			pts[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			due_points.insert(due_points.size(), pts[k]);
		hist_head = (slot + 1) % HIST_DEPTH;
	endtask

	task automatic trace_circle(input logic func, input logic [RW-1:0] radius);
		int         rad;
		circle_pt_t done_pt;
		if (func == mpc_pkg::FUNC_START) begin
			rad = int'(radius);
			if (rad > int'(mpc_pkg::MAX_RADIUS))
				rad = int'(mpc_pkg::MAX_RADIUS);
			pos_x       = 0;
			pos_y       = rad;
			dec_var     = 3 - 2 * rad;
			circle_idle = 1'b0;
			for (int s = 0; s < HIST_DEPTH; s++)
				for (int o = 0; o < NO; o++)
					hist_v[s][o] = 1'b0;
			hist_head = 0;
			emit_mirrors();
		end else if (!circle_idle && pos_y >= pos_x) begin
			pos_x++;
			if (dec_var > 0) begin
				pos_y--;
				dec_var += 4 * (pos_x - pos_y) + 10;
			end else begin
				dec_var += 4 * pos_x + 6;
			end
			emit_mirrors();
		end else begin
			circle_idle = 1'b1;
			done_pt = '{mpc_pkg::coord_t'(0), mpc_pkg::coord_t'(0), OW'(0), 1'b0, 1'b1, 1'b1};
			due_points.insert(due_points.size(), done_pt);
		end
	endtask

	function automatic void check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			fail_cnt++;
		end
	endfunction

	task automatic queue_req(input logic func, input int radius);
		circle_req_t r;
		r = '{func, RW'(radius)};
		circle_reqs.insert(circle_reqs.size(), r);
	endtask

	// monitor: both channels sampled at the rising edge
	always @(posedge clk) begin
		circle_pt_t exp_pt;
		req_hs = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
		res_hs = (res_ch.valid === 1'b1) && (res_ch.ready === 1'b1);
		if (req_hs)
			trace_circle(req_ch.func, req_ch.radius);
		if (res_hs) begin
			res_seen++;
			if (due_points.size() == 0) begin
				$error("unexpected result: point_x %0d point_y %0d octant %0d done_res %0b",
					res_ch.point_x, res_ch.point_y, res_ch.octant, res_ch.done_res);
				fail_cnt++;
			end else begin
				exp_pt = due_points.pop_front();
				check_field("point_x", exp_pt.px, res_ch.point_x);
				check_field("point_y", exp_pt.py, res_ch.point_y);
				check_field("octant", exp_pt.oct, res_ch.octant);
				check_field("point_valid", exp_pt.pv, res_ch.point_valid);
				check_field("last", exp_pt.last, res_ch.last);
				check_field("done_res", exp_pt.done, res_ch.done_res);
			end
		end
		if (req_hs || res_hs)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// request driver
	int   req_gap  = 0;
	logic req_calm = 1'b0;

	always @(negedge clk) begin
		circle_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_hs) begin
			if (req_gap > 0) begin
				req_ch.valid <= 1'b0;
				req_gap--;
			end else if (circle_reqs.size() != 0) begin
				nxt = circle_reqs.pop_front();
				req_ch.valid  <= 1'b1;
				req_ch.func   <= nxt.func;
				req_ch.radius <= nxt.radius;
				if ($urandom_range(0, 19) == 0)
					req_calm = !req_calm;
				req_gap = req_calm ? 0 : $urandom_range(0, GAP_MAX);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver with two long hold-offs
	int   res_wait  = 0;
	int   hold_left = 0;
	logic res_calm  = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else if (res_hs && (res_seen == HOLD_AT_FIRST || res_seen == HOLD_AT_SECOND)) begin
			res_ch.ready <= 1'b0;
			hold_left = HOLD_CYCLES - 1;
		end else if (!res_ch.ready || res_hs) begin
			if (res_hs) begin
				if ($urandom_range(0, 19) == 0)
					res_calm = !res_calm;
				res_wait = res_calm ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (res_wait > 0) begin
				res_ch.ready <= 1'b0;
				res_wait--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int rad;
		int steps;
		int roll;
		req_ch.valid  = 1'b0;
		req_ch.func   = mpc_pkg::FUNC_START;
		req_ch.radius = '0;
		res_ch.ready  = 1'b0;
		arst_n        = 1'b0;

		// step with no circle running
		queue_req(mpc_pkg::FUNC_STEP, 0);
		// radius one: repeats in the start, a fully suppressed step, then the end
		queue_req(mpc_pkg::FUNC_START, 1);
		repeat (3) queue_req(mpc_pkg::FUNC_STEP, $urandom_range(0, 2047));
		// radius zero
		queue_req(mpc_pkg::FUNC_START, 0);
		repeat (2) queue_req(mpc_pkg::FUNC_STEP, 2047);
		// largest radius, dropped by a new start while active
		queue_req(mpc_pkg::FUNC_START, 2047);
		repeat (2) queue_req(mpc_pkg::FUNC_STEP, $urandom_range(0, 2047));
		queue_req(mpc_pkg::FUNC_START, 2);
		repeat (4) queue_req(mpc_pkg::FUNC_STEP, $urandom_range(0, 2047));
		queue_req(mpc_pkg::FUNC_START, 'h555);
		queue_req(mpc_pkg::FUNC_STEP, 'h2AA);
		queue_req(mpc_pkg::FUNC_START, 'h2AA);
		queue_req(mpc_pkg::FUNC_STEP, 'h555);
		queue_req(mpc_pkg::FUNC_START, 3);
		repeat (3) queue_req(mpc_pkg::FUNC_STEP, $urandom_range(0, 2047));

		while (circle_reqs.size() < REQ_GOAL) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				queue_req(mpc_pkg::FUNC_STEP, $urandom_range(0, 2047));
			end else begin
				if (roll < 80)
					rad = $urandom_range(1, 24);
				else if (roll < 92)
					rad = $urandom_range(0, 2047);
				else
					rad = $urandom_range(2000, 2047);
				steps = (rad * 3) / 4 + 2;
				if (rad > 64)
					steps = $urandom_range(1, 10);
				else if ($urandom_range(0, 3) == 0)
					steps = $urandom_range(0, steps);
				queue_req(mpc_pkg::FUNC_START, rad);
				repeat (steps) queue_req(mpc_pkg::FUNC_STEP, $urandom_range(0, 2047));
			end
		end

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		while (circle_reqs.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (due_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
